[rtl/radio_api_frame_builder_core_assert.svh]
// assertion macros for the frame builder back end (rafb_back)
`ifndef RADIO_API_FRAME_BUILDER_CORE_ASSERT_SVH
`define RADIO_API_FRAME_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RAFB_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RAFB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/rafb_pkg.sv]
`timescale 1ns / 1ps
package rafb_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned STEP_W      = 5;

  // frame-data length overhead per mode
  localparam logic [15:0] CMD_OVERHEAD = 16'd4;
  localparam logic [15:0] TX_OVERHEAD  = 16'd14;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_DELIM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_TYPE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TX_TYPE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NET_ADDR    = 8'd3;

  // serializer positions within one frame
  localparam logic [STEP_W-1:0] STEP_DELIM     = 5'd0;
  localparam logic [STEP_W-1:0] STEP_LEN_HI    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_LEN_LO    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_FTYPE     = 5'd3;
  localparam logic [STEP_W-1:0] STEP_FID       = 5'd4;
  localparam logic [STEP_W-1:0] STEP_CMD1      = 5'd5;
  localparam logic [STEP_W-1:0] STEP_CMD2      = 5'd6;
  localparam logic [STEP_W-1:0] STEP_DEST0     = 5'd5;
  localparam logic [STEP_W-1:0] STEP_DEST_LAST = 5'd12;
  localparam logic [STEP_W-1:0] STEP_ADDR_HI   = 5'd13;
  localparam logic [STEP_W-1:0] STEP_ADDR_LO   = 5'd14;
  localparam logic [STEP_W-1:0] STEP_RADIUS    = 5'd15;
  localparam logic [STEP_W-1:0] STEP_OPTS      = 5'd16;
  localparam logic [STEP_W-1:0] STEP_DATA      = 5'd17;
  localparam logic [STEP_W-1:0] STEP_SUM       = 5'd18;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;

  typedef struct packed {
    logic [7:0]  start_delimiter;
    logic [7:0]  command_frame_type;
    logic [7:0]  transmit_frame_type;
    logic [15:0] tx_net_addr;
  } cfg_t;

  // one classified item waiting for the serializer
  typedef struct packed {
    logic             hdr;
    logic             mode;
    logic [7:0]       frame_id;
    logic [7:0]       command_first;
    logic [7:0]       command_second;
    logic [63:0]      destination;
    logic [7:0]       broadcast_radius;
    logic [7:0]       transmit_options;
    logic [LEN_W-1:0] len;
    logic             has_data;
    logic [7:0]       data_byte;
    logic             close;
  } q_entry_t;

endpackage

[rtl/rafb_front.sv]
`timescale 1ns / 1ps
module rafb_front import rafb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  input  logic [7:0]       frame_id_i,
  input  logic [7:0]       command_first_i,
  input  logic [7:0]       command_second_i,
  input  logic [63:0]      destination_i,
  input  logic [7:0]       broadcast_radius_i,
  input  logic [7:0]       transmit_options_i,
  input  logic [LEN_W-1:0] payload_length_i,
  input  logic [7:0]       data_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output q_entry_t         entry_o
);

  logic             open_q, open_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [LEN_W-1:0] len_sat;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign len_sat = (payload_length_i > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                            : payload_length_i;

  always_comb begin
    entry_o.hdr              = !open_q;
    entry_o.mode             = mode_i;
    entry_o.frame_id         = frame_id_i;
    entry_o.command_first    = command_first_i;
    entry_o.command_second   = command_second_i;
    entry_o.destination      = destination_i;
    entry_o.broadcast_radius = broadcast_radius_i;
    entry_o.transmit_options = transmit_options_i;
    entry_o.len              = len_sat;
    entry_o.data_byte        = data_byte_i;
    if (!open_q) begin
      entry_o.has_data = (len_sat != '0);
      entry_o.close    = (len_sat <= LEN_W'(1));
      open_d           = (len_sat > LEN_W'(1));
      left_d           = len_sat - LEN_W'(1);
    end else begin
      entry_o.has_data = 1'b1;
      entry_o.close    = (left_q == LEN_W'(1));
      open_d           = (left_q != LEN_W'(1));
      left_d           = left_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
    end else if (push_o) begin
      open_q <= open_d;
      left_q <= open_d ? left_d : '0;
    end
  end

endmodule

[rtl/rafb_queue.sv]
`timescale 1ns / 1ps
module rafb_queue import rafb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output q_entry_t head_o
);

  q_entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_PTR_W:0]     cnt_q;

  assign full_o       = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + Q_PTR_W'(1);
      end
      cnt_q <= cnt_q + (Q_PTR_W+1)'(push_i) - (Q_PTR_W+1)'(pop_i);
    end
  end

endmodule

[rtl/rafb_back.sv]
`timescale 1ns / 1ps
module rafb_back import rafb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       head_valid_i,
  input  q_entry_t   head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       frame_end_o
);

`include "radio_api_frame_builder_core_assert.svh"

  logic              mid_q;
  logic [STEP_W-1:0] step_q, step_d, cur_step;
  logic [7:0]        sum_q, sum_d;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              last_q, end_q;

  logic              adv, is_last, hdr_end;
  logic [7:0]        byte_v;
  logic [15:0]       fdl;
  logic [2:0]        didx;

  assign adv      = head_valid_i && (!out_valid_q || out_ready_i);
  assign cur_step = mid_q ? step_q : (head_i.hdr ? STEP_DELIM : STEP_DATA);
  assign fdl      = (head_i.mode ? TX_OVERHEAD : CMD_OVERHEAD) + 16'(head_i.len);
  assign didx     = 3'(STEP_DEST_LAST - cur_step);
  assign pop_o    = adv && is_last;

  // byte for the current position
  always_comb begin
    byte_v = '0;
    if (head_i.mode && (cur_step inside {[STEP_DEST0:STEP_DEST_LAST]})) begin
      byte_v = head_i.destination[8*didx +: 8];
    end else begin
      case (cur_step)
        STEP_DELIM:   byte_v = cfg_i.start_delimiter;
        STEP_LEN_HI:  byte_v = fdl[15:8];
        STEP_LEN_LO:  byte_v = fdl[7:0];
        STEP_FTYPE:   byte_v = head_i.mode ? cfg_i.transmit_frame_type
                                           : cfg_i.command_frame_type;
        STEP_FID:     byte_v = head_i.frame_id;
        STEP_CMD1:    byte_v = head_i.command_first;
        STEP_CMD2:    byte_v = head_i.command_second;
        STEP_ADDR_HI: byte_v = cfg_i.tx_net_addr[15:8];
        STEP_ADDR_LO: byte_v = cfg_i.tx_net_addr[7:0];
        STEP_RADIUS:  byte_v = head_i.broadcast_radius;
        STEP_OPTS:    byte_v = head_i.transmit_options;
        STEP_DATA:    byte_v = head_i.data_byte;
        STEP_SUM:     byte_v = ~sum_q;
        default:      byte_v = '0;
      endcase
    end
  end

  // sequencing and running checksum
  always_comb begin
    hdr_end = head_i.mode ? (cur_step == STEP_OPTS) : (cur_step == STEP_CMD2);
    is_last = 1'b0;
    step_d  = cur_step + STEP_W'(1);
    if (cur_step == STEP_SUM) begin
      is_last = 1'b1;
    end else if (cur_step == STEP_DATA) begin
      is_last = !head_i.close;
      step_d  = STEP_SUM;
    end else if (hdr_end) begin
      step_d = head_i.has_data ? STEP_DATA : STEP_SUM;
    end

    sum_d = sum_q;
    if (cur_step == STEP_DELIM || cur_step == STEP_SUM) begin
      sum_d = '0;
    end else if (cur_step >= STEP_FTYPE && cur_step <= STEP_DATA) begin
      sum_d = sum_q + byte_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q       <= 1'b0;
      step_q      <= STEP_DELIM;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        mid_q       <= !is_last;
        step_q      <= step_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= byte_v;
      last_q     <= is_last;
      end_q      <= (cur_step == STEP_SUM);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign frame_end_o   = end_q;

  `RAFB_ASSERT(a_mid_has_entry, mid_q, head_valid_i, "item in progress left the queue")
  `RAFB_ASSERT(a_step_range, mid_q, step_q <= STEP_SUM, "serializer position out of range")
  `RAFB_ASSERT(a_sum_is_last, adv && cur_step == STEP_SUM, pop_o, "checksum not last of item")
  `RAFB_ASSERT(a_data_item_start, adv && !mid_q && !head_i.hdr, cur_step == STEP_DATA,
    "data item did not start at payload byte")
  `RAFB_ASSERT_NEXT(a_checksum_clears_sum, adv && cur_step == STEP_SUM, sum_q == 8'd0,
    "running sum not cleared after checksum")

endmodule

[rtl/radio_api_frame_builder_core.sv]
`timescale 1ns / 1ps
// radio api frame builder
// in channel: in_valid_i / in_ready_o, one item per handshake. the first item of a
//   frame carries mode, frame id, header fields and payload length (saturated to 256)
//   plus the first payload byte; later items carry one payload byte each.
// out channel: out_valid_o / out_ready_i, one frame byte per item, with last_of_run_o
//   on the final byte caused by an input item and frame_end_o on the checksum byte.
// cfg channel: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i picks the register
//   (0 delimiter, 1 command type, 2 transmit type, 3 network address), others ignored.
// an accepted item passes through the queue and then the output register before its first byte appears.
// throughput: the serializer emits one byte per cycle unless the queue is empty or the
//   output stalls; a frame-start item yields 8 to 19 bytes (header length by mode,
//   payload byte, checksum), a payload item 1 byte or 2 on the last byte of the frame.
// a 2-entry queue separates the classifying front from the serializer; while the
//   receiver stalls the output register holds its byte and input is still taken until
//   the queue fills, then in_ready_o drops.
// reset: registers return to their defaults, no frame is open, queue and output empty.
module radio_api_frame_builder_core import rafb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [7:0]            frame_id_i,
  input  logic [7:0]            command_first_i,
  input  logic [7:0]            command_second_i,
  input  logic [63:0]           destination_i,
  input  logic [7:0]            broadcast_radius_i,
  input  logic [7:0]            transmit_options_i,
  input  logic [LEN_W-1:0]      payload_length_i,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o,
  output logic                  frame_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t     cfg_q;
  logic     push, q_full, pop, head_valid;
  q_entry_t entry, head;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delimiter     <= 8'h7E;
      cfg_q.command_frame_type  <= 8'h08;
      cfg_q.transmit_frame_type <= 8'h10;
      cfg_q.tx_net_addr         <= 16'hFFFE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_DELIM: cfg_q.start_delimiter     <= cfg_data_i[7:0];
        REG_CMD_TYPE:    cfg_q.command_frame_type  <= cfg_data_i[7:0];
        REG_TX_TYPE:     cfg_q.transmit_frame_type <= cfg_data_i[7:0];
        REG_NET_ADDR:    cfg_q.tx_net_addr         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: frame tracking and item classification
  rafb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .frame_id_i         (frame_id_i),
    .command_first_i    (command_first_i),
    .command_second_i   (command_second_i),
    .destination_i      (destination_i),
    .broadcast_radius_i (broadcast_radius_i),
    .transmit_options_i (transmit_options_i),
    .payload_length_i   (payload_length_i),
    .data_byte_i        (data_byte_i),
    .q_full_i           (q_full),
    .push_o             (push),
    .entry_o            (entry)
  );

  // decoupling queue
  rafb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: byte serializer, checksum and output register
  rafb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import rafb_pkg::*;

  // one input item as driven onto the in channel
  typedef struct packed {
    logic             mode;
    logic [7:0]       frame_id;
    logic [7:0]       command_first;
    logic [7:0]       command_second;
    logic [63:0]      destination;
    logic [7:0]       broadcast_radius;
    logic [7:0]       transmit_options;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_byte;
  } api_item_t;

  // one serialized frame byte as seen on the out channel
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
  } frame_byte_t;

  // an index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // in channel
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  api_item_t   cur_item = '0;
  logic        in_taken = 1'b0;

  // out channel
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;
  logic        frame_end_o;

  // cfg channel
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // stimulus and scoreboard
  api_item_t   tx_items_q[$];
  frame_byte_t frame_bytes_q[$];
  int unsigned mismatch_cnt = 0;
  logic        calm = 1'b0;

  // predictor state
  cfg_t             regs_m;
  logic             frame_open_m;
  logic [LEN_W-1:0] bytes_left_m;
  logic [7:0]       sum_m;

  always #5ns clk_i = ~clk_i;

  radio_api_frame_builder_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (cur_item.mode),
    .frame_id_i         (cur_item.frame_id),
    .command_first_i    (cur_item.command_first),
    .command_second_i   (cur_item.command_second),
    .destination_i      (cur_item.destination),
    .broadcast_radius_i (cur_item.broadcast_radius),
    .transmit_options_i (cur_item.transmit_options),
    .payload_length_i   (cur_item.payload_length),
    .data_byte_i        (cur_item.data_byte),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .last_of_run_o      (last_of_run_o),
    .frame_end_o        (frame_end_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // frame predictor
  // ---------------------------------------------------------------------------

  // lengths above the maximum payload are clipped
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : len;
  endfunction

  // byte outside the checksum (delimiter, length field, checksum itself)
  task automatic put_raw(input logic [7:0] b, input logic is_sum);
    frame_bytes_q.push_back(frame_byte_t'{out_byte: b, last_of_run: 1'b0, frame_end: is_sum});
  endtask

  // frame-data byte, counted in the checksum
  task automatic put_data(input logic [7:0] b);
    put_raw(b, 1'b0);
    sum_m = sum_m + b;
  endtask

  task automatic put_checksum();
    put_raw(8'hFF - sum_m, 1'b1);
    frame_open_m = 1'b0;
    bytes_left_m = '0;
    sum_m        = '0;
  endtask

  // expected bytes for one accepted item, appended to frame_bytes_q
  task automatic build_frame_bytes(input api_item_t it);
    logic [LEN_W-1:0] len;
    logic [15:0]      fdl;
    frame_byte_t      tail;
    if (!frame_open_m) begin
      len   = sat_len(it.payload_length);
      fdl   = (it.mode ? TX_OVERHEAD : CMD_OVERHEAD) + 16'(len);
      sum_m = '0;
      put_raw(regs_m.start_delimiter, 1'b0);
      put_raw(fdl[15:8], 1'b0);
      put_raw(fdl[7:0], 1'b0);
      if (!it.mode) begin
        // local command: type, id, two command characters
        put_data(regs_m.command_frame_type);
        put_data(it.frame_id);
        put_data(it.command_first);
        put_data(it.command_second);
      end else begin
        // transmit request: type, id, destination msb first, address, radius, options
        put_data(regs_m.transmit_frame_type);
        put_data(it.frame_id);
        for (int i = 7; i >= 0; i--) put_data(it.destination[i*8 +: 8]);
        put_data(regs_m.tx_net_addr[15:8]);
        put_data(regs_m.tx_net_addr[7:0]);
        put_data(it.broadcast_radius);
        put_data(it.transmit_options);
      end
      if (len == 0) begin
        // empty payload closes the frame at once, data byte ignored
        put_checksum();
      end else begin
        put_data(it.data_byte);
        bytes_left_m = len - 1'b1;
        frame_open_m = 1'b1;
        if (bytes_left_m == 0) put_checksum();
      end
    end else begin
      // mid-frame: only the data byte matters
      put_data(it.data_byte);
      if (bytes_left_m != 0) bytes_left_m = bytes_left_m - 1'b1;
      if (bytes_left_m == 0) put_checksum();
    end
    // every item produces at least one byte, flag the final one
    tail = frame_bytes_q.pop_back();
    tail.last_of_run = 1'b1;
    frame_bytes_q.push_back(tail);
  endtask

  task automatic check_byte(input frame_byte_t got);
    frame_byte_t want;
    if (frame_bytes_q.size() == 0) begin
      if (mismatch_cnt < 10)
        $display("%0t: unexpected byte %02h last %b end %b", $realtime,
                 got.out_byte, got.last_of_run, got.frame_end);
      mismatch_cnt++;
    end else begin
      want = frame_bytes_q.pop_front();
      if (want !== got) begin
        if (mismatch_cnt < 10)
          $display("%0t: byte mismatch, exp %02h last %b end %b, got %02h last %b end %b",
                   $realtime, want.out_byte, want.last_of_run, want.frame_end,
                   got.out_byte, got.last_of_run, got.frame_end);
        mismatch_cnt++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // in channel: load the next item once the current one is taken, sometimes idle
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (tx_items_q.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
        cur_item   <= tx_items_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // out channel: random stalls except in calm stretches
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) build_frame_bytes(cur_item);
    if (rst_ni && out_valid_o && out_ready_i)
      check_byte(frame_byte_t'{out_byte: out_byte_o, last_of_run: last_of_run_o,
                               frame_end: frame_end_o});
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // register write, mirrored into the predictor on the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_START_DELIM: regs_m.start_delimiter     = val[7:0];
      REG_CMD_TYPE:    regs_m.command_frame_type  = val[7:0];
      REG_TX_TYPE:     regs_m.transmit_frame_type = val[7:0];
      REG_NET_ADDR:    regs_m.tx_net_addr         = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] delim, input logic [15:0] cmd_type,
                           input logic [15:0] tx_type, input logic [15:0] addr);
    write_reg(REG_START_DELIM, delim);
    write_reg(REG_CMD_TYPE, cmd_type);
    write_reg(REG_TX_TYPE, tx_type);
    write_reg(REG_NET_ADDR, addr);
  endtask

  // fully random item, also used as mid-frame payload with junk header fields
  function automatic api_item_t random_item();
    api_item_t it;
    it.mode             = 1'($urandom_range(1));
    it.frame_id         = 8'($urandom);
    it.command_first    = 8'($urandom);
    it.command_second   = 8'($urandom);
    it.destination      = {$urandom, $urandom};
    it.broadcast_radius = 8'($urandom);
    it.transmit_options = 8'($urandom);
    it.payload_length   = 9'($urandom);
    it.data_byte        = 8'($urandom);
    return it;
  endfunction

  // frame start with mostly short payloads
  function automatic api_item_t random_header();
    api_item_t   it;
    int unsigned pick;
    it   = random_item();
    pick = $urandom_range(99);
    if (pick < 8)       it.payload_length = '0;
    else if (pick < 60) it.payload_length = 9'($urandom_range(4, 1));
    else if (pick < 92) it.payload_length = 9'($urandom_range(16, 5));
    else                it.payload_length = 9'($urandom_range(48, 17));
    return it;
  endfunction

  // header item followed by the rest of the payload, returns items queued
  task automatic queue_frame(input api_item_t hdr, inout int queued);
    logic [LEN_W-1:0] len;
    len = sat_len(hdr.payload_length);
    tx_items_q.push_back(hdr);
    queued++;
    for (int k = 1; k < len; k++) begin
      tx_items_q.push_back(random_item());
      queued++;
    end
  endtask

  // blocks until nothing is in flight, then lets the pipeline settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (tx_items_q.size() != 0 || in_valid_i || frame_bytes_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n_items, input logic no_gaps);
    int queued;
    queued = 0;
    calm   = no_gaps;
    while (queued < n_items) queue_frame(random_header(), queued);
    wait_drained();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    api_item_t it;
    int        queued;
    queued = 0;

    // predictor reset values
    regs_m.start_delimiter     = 8'h7E;
    regs_m.command_frame_type  = 8'h08;
    regs_m.transmit_frame_type = 8'h10;
    regs_m.tx_net_addr         = 16'hFFFE;
    frame_open_m = 1'b0;
    bytes_left_m = '0;
    sum_m        = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    // directed frames under reset register values

    // command frame, empty payload, all fields high
    it = random_item();
    it.mode = 1'b0; it.frame_id = 8'hFF; it.command_first = 8'hFF;
    it.command_second = 8'hFF; it.payload_length = '0; it.data_byte = 8'hFF;
    queue_frame(it, queued);
    // transmit frame, empty payload, frame id low and other fields high
    it = random_item();
    it.mode = 1'b1; it.frame_id = 8'h00; it.destination = '1;
    it.broadcast_radius = 8'hFF; it.transmit_options = 8'hFF; it.payload_length = '0;
    queue_frame(it, queued);
    // command frame, empty payload, all fields low
    it = '0;
    queue_frame(it, queued);
    // one payload byte: header, data and checksum on the same item
    it = random_item();
    it.mode = 1'b0; it.payload_length = 9'd1; it.data_byte = 8'hFF;
    queue_frame(it, queued);
    // transmit, one payload byte, destination and options low
    it = '0;
    it.mode = 1'b1; it.payload_length = 9'd1;
    queue_frame(it, queued);
    // two-byte transmit frame, junk header fields on the second item
    it = random_item();
    it.mode = 1'b1; it.payload_length = 9'd2;
    queue_frame(it, queued);
    // command frame with three bytes
    it = random_item();
    it.mode = 1'b0; it.payload_length = 9'd3; it.data_byte = 8'h00;
    queue_frame(it, queued);
    // transmit frame with a patterned destination
    it = random_item();
    it.mode = 1'b1; it.destination = 64'h0123_4567_89AB_CDEF; it.payload_length = 9'd5;
    queue_frame(it, queued);
    // transmit frame with an inverted pattern
    it = random_item();
    it.mode = 1'b1; it.destination = 64'hFEDC_BA98_7654_3210; it.payload_length = 9'd4;
    queue_frame(it, queued);
    wait_drained();

    // registers all low, plus writes past the register list that must do nothing
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_TOP, 16'hFFFF);
    random_phase(80, 1'b0);

    // registers all high, long stretch without idling on either side
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(80, 1'b1);

    // random registers, one oversized frame clipped to the maximum payload
    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    it = random_item();
    it.payload_length = 9'($urandom_range(511, 257));
    queued = 0;
    queue_frame(it, queued);
    random_phase(20, 1'b0);

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(20, 1'b0);

    // final settle, any stray byte shows up as unexpected
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0 && frame_bytes_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000ns;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rafb_pkg.sv
rtl/rafb_front.sv
rtl/rafb_queue.sv
rtl/rafb_back.sv
rtl/radio_api_frame_builder_core.sv
bench/testbench.sv
